// File: hw/rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg: shared types and constants for the mangled-name decoder
// Channel payloads, controller/datapath command and status groups, the
// state encoding and the dollar-token table.
// ----------------------------------------------------------------------------
package smd_pkg;

  // Window of bytes under scan: up to seven held bytes plus the new one
  localparam int WinDepth  = 8;
  localparam int CntW      = 4;   // holds 0..WinDepth
  localparam int NumTokens = 18;
  localparam int TokMax    = 7;   // longest token text after the '$'
  localparam int HexLen    = 6;   // "$u" plus four hex digits

  localparam logic [7:0] ChDollar = "$";
  localparam logic [7:0] ChU      = "u";

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t in_byte;
    logic  end_of_name;
  } in_item_t;

  typedef struct packed {
    byte_t out_byte;
    logic  last;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the input byte into the window
    logic step;   // emit one decoded byte and consume its source bytes
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;     // window holds no bytes
    logic hold;      // head is a partial match, wait for more input
    logic drained;   // the next step consumes the whole window
    logic out_free;  // output register can take a byte this cycle
  } ctl_status_t;

  // Token text after the '$', left aligned, padded with spaces
  localparam logic [8*TokMax-1:0] TokText [NumTokens] = '{
    "tilde  ", "eq     ", "less   ", "greater", "bang   ", "hash   ",
    "percent", "up     ", "amp    ", "bar    ", "times  ", "div    ",
    "plus   ", "minus  ", "colon  ", "bslash ", "qmark  ", "at     "
  };

  // Full token length including the '$'
  localparam logic [CntW-1:0] TokLen [NumTokens] = '{
    4'd6, 4'd3, 4'd5, 4'd8, 4'd5, 4'd5,
    4'd8, 4'd3, 4'd4, 4'd4, 4'd6, 4'd4,
    4'd5, 4'd6, 4'd6, 4'd7, 4'd6, 4'd3
  };

  localparam byte_t TokChar [NumTokens] = '{
    "~", "=", "<", ">", "!", "#",
    "%", "^", "&", "|", "*", "/",
    "+", "-", ":", "\\", "?", "@"
  };

endpackage

// File: hw/rtl/smd_ctrl.sv
// ----------------------------------------------------------------------------
// smd_ctrl: sequencing controller
// Accepts one byte in idle, then steps the datapath one decoded byte per
// cycle while the output register is free, until the window drains or a partial match has to wait.
// ----------------------------------------------------------------------------
module smd_ctrl
  import smd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ctl_status_t status,
  output ctl_cmd_t    cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (status.empty || status.hold) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.drained) state_nxt = ST_IDLE;
        end else begin
          // output register busy: wait
          state_nxt = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/smd_datapath.sv
// ----------------------------------------------------------------------------
// smd_datapath: byte window, token matcher and output register
// The window head is classified each cycle; a step emits one byte and
// shifts the consumed bytes out of the window.
// ----------------------------------------------------------------------------
module smd_datapath
  import smd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  ctl_cmd_t    cmd,
  output ctl_status_t status,
  input  logic        out_stall,
  output logic        out_valid,
  output out_item_t   out_data
);

  function automatic logic is_hex(input byte_t c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nib(input byte_t c);
    logic [3:0] v;
    if (c >= "0" && c <= "9")      v = 4'(c - "0");
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
    else                           v = 4'(c - "A" + 8'd10);
    return v;
  endfunction

  logic [WinDepth-1:0][7:0] win_r, win_nxt;
  logic [CntW-1:0]          cnt_r, cnt_nxt;
  logic                     eon_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic            tok_full, tok_poss, hex_match, hex_full, any_poss;
  logic            mk;
  byte_t           tok_ch, emit_byte;
  logic [CntW-1:0] tok_used, used;
  logic            hold_w, last_w, out_free;

  // token and hex-escape matcher on the window head
  always_comb begin
    tok_full = 1'b0;
    tok_poss = 1'b0;
    tok_ch   = ChDollar;
    tok_used = 4'd1;
    for (int k = 0; k < NumTokens; k++) begin
      mk = 1'b1;
      for (int j = 1; j < WinDepth; j++) begin
        if (j < int'(cnt_r) && j < int'(TokLen[k]) &&
            win_r[j] != TokText[k][8*(TokMax-j) +: 8]) begin
          mk = 1'b0;
        end
      end
      if (mk && cnt_r >= TokLen[k]) begin
        tok_full = 1'b1;
        tok_ch   = TokChar[k];
        tok_used = TokLen[k];
      end
      if (mk && cnt_r < TokLen[k]) tok_poss = 1'b1;
    end

    hex_match = (cnt_r >= 4'd2) && (win_r[1] == ChU);
    for (int j = 2; j < HexLen; j++) begin
      if (j < int'(cnt_r) && !is_hex(win_r[j])) hex_match = 1'b0;
    end
    hex_full = hex_match && (cnt_r >= 4'(HexLen));
    any_poss = tok_poss || (hex_match && !hex_full) || (cnt_r == 4'd1);
  end

  // pick what the head emits, or hold it
  always_comb begin
    hold_w    = 1'b0;
    emit_byte = ChDollar;
    used      = 4'd1;
    priority if (win_r[0] != ChDollar) begin
      emit_byte = win_r[0];
    end else if (tok_full) begin
      emit_byte = tok_ch;
      used      = tok_used;
    end else if (hex_full) begin
      emit_byte = {hex_nib(win_r[4]), hex_nib(win_r[5])};
      used      = 4'(HexLen);
    end else if (any_poss && !eon_r) begin
      hold_w = 1'b1;
    end else begin
      // dead '$' passes through as text
      emit_byte = ChDollar;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign last_w   = eon_r && (cnt_r == used);

  always_comb begin
    status.empty    = (cnt_r == '0);
    status.hold     = hold_w;
    status.drained  = (cnt_r == used);
    status.out_free = out_free;
  end

  // window update: append on load, shift out consumed bytes on step
  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      win_nxt[cnt_r[2:0]] = in_data.in_byte;
      cnt_nxt             = cnt_r + 4'd1;
    end else if (cmd.step) begin
      win_nxt = win_r >> {used, 3'b000};
      cnt_nxt = cnt_r - used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (cmd.load) eon_r <= in_data.end_of_name;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_data_r.out_byte <= emit_byte;
      out_data_r.last     <= last_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (cnt_r < 4'(WinDepth)))
    else $error("byte loaded into a full window");

  a_step_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (cnt_r != '0) && out_free && !hold_w)
    else $error("step on empty window, busy output or held match");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && last_w) |=> (cnt_r == '0))
    else $error("bytes left in window after last transfer of a name");

  a_eon_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (eon_r && cnt_r != '0) |-> !hold_w)
    else $error("held bytes at end of name");

endmodule

// File: hw/rtl/symbol_name_mangle_decoder.sv
// ----------------------------------------------------------------------------
// symbol_name_mangle_decoder: streaming decoder for mangled operator names
//
//   channel  ports                              payload
//   input    in_valid, in_stall, in_data        in_byte, end_of_name
//   output   out_valid, out_stall, out_data     out_byte, last
//
// A byte is taken in idle, then the datapath emits one decoded byte per
// cycle while the output register is free, until the window drains or the
// head holds a partial match. Each step is a single match-and-shift on the
// eight-byte window.
// Reset (rst_n low, synchronous) empties the window and the output register.
// A stalled output freezes the scan; a new byte is taken only in idle.
// ----------------------------------------------------------------------------
module symbol_name_mangle_decoder
  import smd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctl_cmd_t    cmd;
  ctl_status_t status;

  smd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  smd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: dv/symbol_name_mangle_decoder_test.sv
// ----------------------------------------------------------------------------
// symbol_name_mangle_decoder_test: self-checking bench for the name decoder
// Sends mangled names a byte at a time through a short table of fixed
// names and then random ones built from tokens, hex escapes, text and broken
// prefixes. Both channels idle at random. Every output transfer is compared
// with a bench-side decoder, or with the decoded text typed into the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module symbol_name_mangle_decoder_test;
  import smd_pkg::*;

  localparam int NUM_OPS      = 18;
  localparam int RAND_BYTES   = 290;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIR_ROWS     = 9;

  typedef enum int {
    MATCH_NONE,
    MATCH_PARTIAL,
    MATCH_FULL
  } match_t;

  // Fixed name, right aligned, and its decoded text (dlen 0: use the decoder)
  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] text;
    logic [3:0]  dlen;
    logic [63:0] decoded;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{4'd1, 64'h00, 4'd1, 64'h00},        // lowest byte value
    '{4'd1, 64'hFF, 4'd1, 64'hFF},        // highest byte value
    '{4'd3, "$eq", 4'd1, "="},
    '{4'd6, "$u00Fe", 4'd1, 64'hFE},      // hex escape, mixed case
    '{4'd3, "$up", 4'd1, "^"},            // token that starts like a hex escape
    '{4'd3, "$u4", 4'd3, "$u4"},          // cut short by end of name
    '{4'd3, "$x$", 4'd3, "$x$"},          // dead '$', then a lone one at the end
    '{4'd1, "$", 4'd1, "$"},
    '{4'd7, "$bslash", 4'd0, 64'h0}
  };

  string op_word [NUM_OPS] = '{
    "tilde", "eq", "less", "greater", "bang", "hash", "percent", "up",
    "amp", "bar", "times", "div", "plus", "minus", "colon", "bslash",
    "qmark", "at"
  };

  byte_t op_sym [NUM_OPS] = '{
    "~", "=", "<", ">", "!", "#", "%", "^", "&", "|", "*", "/",
    "+", "-", ":", "\\", "?", "@"
  };

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Sideband carried along with each input transfer
  int        feed_row   = -1;
  bit        feed_first = 1'b0;

  // Decoder state on the bench side
  byte_t     held_win [7];
  int        held_cnt = 0;
  out_item_t step_out [$];
  out_item_t decoded_q [$];

  byte_t     name_q [$];
  out_item_t want;
  int        gap_pct = 0;
  int        stall_pct = 0;
  int        stall_run = 0;
  int        errors = 0;
  int        bytes_sent = 0;
  int        names_sent = 0;
  int        outs_checked = 0;
  int        cycles = 0;
  int        ti;

  symbol_name_mangle_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decoder on the bench side
  // --------------------------------------------------------------------------
  function automatic int hex_val(input byte_t c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  // win[base] is a '$' with avail bytes from there on
  function automatic match_t match_dollar(input byte_t win [8], input int base,
                                          input int avail, output byte_t sym,
                                          output int span);
    bit maybe;
    bit ok;
    int k, j, tl, upto;
    maybe = 1'b0;
    sym   = 8'h00;
    span  = 1;
    for (k = 0; k < NUM_OPS; k++) begin
      tl   = op_word[k].len() + 1;
      upto = (avail < tl) ? avail : tl;
      ok   = 1'b1;
      for (j = 1; j < upto; j++)
        if (win[base + j] != byte_t'(op_word[k][j - 1])) ok = 1'b0;
      if (ok) begin
        if (avail >= tl) begin
          sym  = op_sym[k];
          span = tl;
          return MATCH_FULL;
        end
        maybe = 1'b1;
      end
    end
    if (avail == 1) return MATCH_PARTIAL;
    // "$u" plus four hex digits
    if (win[base + 1] == "u") begin
      upto = (avail < 6) ? avail : 6;
      ok   = 1'b1;
      for (j = 2; j < upto; j++)
        if (hex_val(win[base + j]) < 0) ok = 1'b0;
      if (ok) begin
        if (avail >= 6) begin
          sym  = byte_t'(hex_val(win[base + 4]) * 16 + hex_val(win[base + 5]));
          span = 6;
          return MATCH_FULL;
        end
        maybe = 1'b1;
      end
    end
    return maybe ? MATCH_PARTIAL : MATCH_NONE;
  endfunction

  // Decode one input byte; results land in step_out
  function automatic void decode_step(input in_item_t it);
    byte_t  win [8];
    byte_t  sym;
    byte_t  emit;
    match_t m;
    int     n, pos, span, j;
    step_out.delete();
    n = held_cnt;
    for (j = 0; j < n; j++) win[j] = held_win[j];
    win[n] = it.in_byte;
    n++;
    pos = 0;
    while (pos < n) begin
      if (win[pos] != "$") begin
        emit = win[pos];
        pos++;
      end else begin
        m = match_dollar(win, pos, n - pos, sym, span);
        if (m == MATCH_FULL) begin
          emit = sym;
          pos += span;
        end else if (m == MATCH_PARTIAL && !it.end_of_name) begin
          break;
        end else begin
          emit = "$";
          pos++;
        end
      end
      step_out.push_back(out_item_t'{out_byte: emit, last: 1'b0});
    end
    held_cnt = 0;
    for (j = pos; j < n && held_cnt < 7; j++) begin
      held_win[held_cnt] = win[j];
      held_cnt++;
    end
    if (it.end_of_name) begin
      held_cnt = 0;
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input monitor and output checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      decode_step(in_data);
      if (feed_row < 0) begin
        foreach (step_out[i]) decoded_q.push_back(step_out[i]);
      end else if (feed_first) begin
        // typed result for the whole name, queued on its first byte
        for (ti = 0; ti < dir_tab[feed_row].dlen; ti++)
          decoded_q.push_back(out_item_t'{
            out_byte: dir_tab[feed_row].decoded[8 * (dir_tab[feed_row].dlen - 1 - ti) +: 8],
            last:     (ti == dir_tab[feed_row].dlen - 1)});
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      outs_checked++;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output, expected nothing, got byte %h last %b",
                 $time, out_data.out_byte, out_data.last);
      end else begin
        want = decoded_q.pop_front();
        if (want.out_byte !== out_data.out_byte || want.last !== out_data.last) begin
          errors++;
          $display("%0t: mismatch, expected byte %h last %b, got byte %h last %b",
                   $time, want.out_byte, want.last, out_data.out_byte, out_data.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idle patterns
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stall: runs of random length
  always @(posedge clk) begin
    if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sending
  // --------------------------------------------------------------------------
  // Called at a clock edge with in_valid low or its transfer just taken
  task automatic send_byte(input in_item_t it, input int row, input bit first);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= it;
    feed_row   <= row;
    feed_first <= first;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_name(input int row);
    int i;
    for (i = 0; i < name_q.size(); i++)
      send_byte(in_item_t'{in_byte: name_q[i], end_of_name: (i == name_q.size() - 1)},
                row, i == 0);
    names_sent++;
  endtask

  // Random name fragments
  task automatic add_token();
    int k, j;
    k = $urandom_range(NUM_OPS - 1);
    name_q.push_back("$");
    for (j = 0; j < op_word[k].len(); j++) name_q.push_back(byte_t'(op_word[k][j]));
  endtask

  task automatic add_hex_digits(input int count);
    int j, v;
    for (j = 0; j < count; j++) begin
      v = $urandom_range(15);
      if (v < 10) name_q.push_back(byte_t'(48 + v));
      else if ($urandom_range(1)) name_q.push_back(byte_t'(87 + v));
      else name_q.push_back(byte_t'(55 + v));
    end
  endtask

  task automatic add_text();
    int j, cnt;
    cnt = $urandom_range(1, 3);
    for (j = 0; j < cnt; j++) begin
      if ($urandom_range(1)) name_q.push_back(byte_t'($urandom_range(255)));
      else name_q.push_back(byte_t'($urandom_range(97, 122)));
    end
  endtask

  // '$' plus a proper prefix of a token or of a hex escape
  task automatic add_broken();
    int k, j, cut;
    name_q.push_back("$");
    if ($urandom_range(1)) begin
      k   = $urandom_range(NUM_OPS - 1);
      cut = $urandom_range(op_word[k].len() - 1);
      for (j = 0; j < cut; j++) name_q.push_back(byte_t'(op_word[k][j]));
    end else begin
      name_q.push_back("u");
      add_hex_digits($urandom_range(3));
    end
  endtask

  task automatic build_random_name();
    int f, nfrag, r;
    name_q.delete();
    nfrag = $urandom_range(1, 4);
    for (f = 0; f < nfrag; f++) begin
      r = $urandom_range(99);
      if (r < 35) add_token();
      else if (r < 55) begin
        name_q.push_back("$");
        name_q.push_back("u");
        add_hex_digits(4);
      end
      else if (r < 80) add_text();
      else if (r < 95) add_broken();
      else name_q.push_back("$");
    end
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------
  initial begin
    int r, i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fixed names, no idling
    for (r = 0; r < DIR_ROWS; r++) begin
      name_q.delete();
      for (i = 0; i < dir_tab[r].len; i++)
        name_q.push_back(dir_tab[r].text[8 * (dir_tab[r].len - 1 - i) +: 8]);
      send_name((dir_tab[r].dlen != 0) ? r : -1);
    end

    // Random names in three idling phases
    r = bytes_sent;
    while (bytes_sent - r < RAND_BYTES) begin
      if (bytes_sent - r < RAND_BYTES / 3) begin
        gap_pct   = 30;
        stall_pct = 30;
      end else if (bytes_sent - r < 2 * RAND_BYTES / 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 70;
        stall_pct = 60;
      end
      build_random_name();
      send_name(-1);
    end
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d names in %0d bytes; compared %0d decoded bytes, %0d mismatches.",
             names_sent, bytes_sent, outs_checked, errors);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycles, decoded_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
